// ===== rtl/core/gche_pkg.sv =====
// ----------------------------------------------------------------------------
// gche_pkg: shared types, constants and functions
// Window and angle sizing, job and result structs, arctangent table and
// the digit step of the divide-by-three used for the centroid.
// ----------------------------------------------------------------------------
`default_nettype none

package gche_pkg;

  localparam int WINDOW_LEN   = 9;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int TAB_W        = $clog2(TAB_LEN);

  localparam int POS_W   = 32;
  localparam int SUM_W   = POS_W + 2;
  localparam int DIGIT_W = 4;
  localparam int DIV_DIGITS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIV_W   = DIV_DIGITS * DIGIT_W;

  localparam int NSTEP  = (CORDIC_STEPS > DIV_DIGITS) ? CORDIC_STEPS : DIV_DIGITS;
  localparam int STEP_W = $clog2(NSTEP);

  localparam int CNT_W = $clog2(WINDOW_LEN + 2);

  localparam int FRAC_SH = 24;
  localparam int CW      = POS_W + FRAC_SH + 3;
  localparam int Z_W     = 32;
  localparam int HEAD_W  = 16;
  localparam int ANG_SH  = Z_W - HEAD_W;

  localparam int LIMIT_W = 15;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd3641;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic             valid;
    logic             west;
    logic             neg;
    logic [POS_W-1:0] ax;
    logic [POS_W-1:0] ay;
    logic [SUM_W-1:0] sum_e;
    logic [SUM_W-1:0] sum_n;
  } gche_job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
  } gche_qstat_t;

  typedef struct packed {
    logic              heading_valid;
    logic [HEAD_W-1:0] heading;
    logic              held_previous;
    logic [POS_W-1:0]  centroid_east;
    logic [POS_W-1:0]  centroid_north;
  } gche_result_t;

  // atan(2^-i) with pi = 2^31
  function automatic logic [Z_W-1:0] atan_at(input logic [TAB_W-1:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // one quotient digit of a divide by three: returns {quotient digit, remainder}
  function automatic logic [DIGIT_W+1:0] div3_digit(input logic [1:0] rem,
                                                     input logic [DIGIT_W-1:0] d);
    logic [2:0]         t;
    logic [1:0]         r;
    logic [DIGIT_W-1:0] q;
    r = rem;
    q = '0;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      t = {r, d[b]};
      if (t >= 3'd3) begin
        q[b] = 1'b1;
        r    = 2'(t - 3'd3);
      end else begin
        q[b] = 1'b0;
        r    = t[1:0];
      end
    end
    return {q, r};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gche_front.sv =====
// ----------------------------------------------------------------------------
// gche_front: fix window and job classification
// Shifts each accepted fix into the window and pushes one job per fix,
// carrying the span, its signs and the centroid sums.
// ----------------------------------------------------------------------------
`default_nettype none

module gche_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  input  wire logic [gche_pkg::POS_W-1:0] in_pos_east,
  input  wire logic [gche_pkg::POS_W-1:0] in_pos_north,
  input  wire gche_pkg::gche_qstat_t      q_stat,
  output logic                            q_push,
  output gche_pkg::gche_job_t             q_job
);

  localparam int LAST = gche_pkg::WINDOW_LEN - 1;
  localparam int PW   = gche_pkg::POS_W;
  localparam int SW   = gche_pkg::SUM_W;
  localparam int CW   = gche_pkg::CNT_W;

  logic [PW-1:0] east_r  [gche_pkg::WINDOW_LEN];
  logic [PW-1:0] north_r [gche_pkg::WINDOW_LEN];
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          accept;
  logic          ready;
  logic [PW:0]   dx, dy, ndx, ndy;
  logic          zero_span;

  assign accept = in_push && !q_stat.full;

  // window payload needs no reset: it is fully refilled before it is used
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < LAST; i++) begin
        east_r[i]  <= east_r[i+1];
        north_r[i] <= north_r[i+1];
      end
      east_r[LAST]  <= in_pos_east;
      north_r[LAST] <= in_pos_north;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && (cnt_r < CW'(gche_pkg::WINDOW_LEN + 1))) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CW'(1);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // after the shift: entry 0 is old entry 1, entry 1 is old entry 2
  assign ready = (cnt_r >= CW'(gche_pkg::WINDOW_LEN + 1)) &&
                 (east_r[1] != '0) && (north_r[1] != '0);

  assign dx  = {1'b0, in_pos_east}  - {1'b0, east_r[2]};
  assign dy  = {1'b0, in_pos_north} - {1'b0, north_r[2]};
  assign ndx = (PW+1)'(-dx);
  assign ndy = (PW+1)'(-dy);

  assign zero_span = (dy == '0) && !dx[PW];

  always_comb begin
    q_job.valid = ready && !zero_span;
    q_job.west  = dx[PW];
    q_job.neg   = (in_pos_north <= north_r[LAST]);
    q_job.ax    = dx[PW] ? ndx[PW-1:0] : dx[PW-1:0];
    q_job.ay    = dy[PW] ? ndy[PW-1:0] : dy[PW-1:0];
    // plus one for round half up in the later divide by three
    q_job.sum_e = SW'(in_pos_east) + SW'(east_r[LAST]) + SW'(east_r[LAST-1]) + SW'(1);
    q_job.sum_n = SW'(in_pos_north) + SW'(north_r[LAST]) + SW'(north_r[LAST-1]) + SW'(1);
  end

  assign q_push = accept;

endmodule

`default_nettype wire

// ===== rtl/core/gche_queue.sv =====
// ----------------------------------------------------------------------------
// gche_queue: job queue between front and back
// Small first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module gche_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire gche_pkg::gche_job_t   wr_job,
  input  wire logic                  pop,
  output gche_pkg::gche_job_t        rd_job,
  output gche_pkg::gche_qstat_t      stat
);

  localparam int PW = gche_pkg::QPTR_W;
  localparam int NW = $clog2(gche_pkg::QUEUE_DEPTH + 1);

  gche_pkg::gche_job_t slot_r [gche_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (num_r == NW'(gche_pkg::QUEUE_DEPTH));
  assign stat.empty = (num_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    num_nxt    = num_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(gche_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(gche_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      num_nxt = num_r + NW'(1);
    end else if (do_pop && !do_push) begin
      num_nxt = num_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      num_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      num_r    <= num_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gche_back.sv =====
// ----------------------------------------------------------------------------
// gche_back: heading and centroid engine
// Iterative vectoring angle, jump limiting and divide by three per job,
// with a one-entry result register toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gche_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire gche_pkg::gche_job_t          job,
  input  wire gche_pkg::gche_qstat_t        q_stat,
  output logic                              q_pop,
  input  wire logic [gche_pkg::LIMIT_W-1:0] jump_limit,
  input  wire logic                         res_pop,
  output logic                              res_valid,
  output gche_pkg::gche_result_t            res
);

  localparam int CW  = gche_pkg::CW;
  localparam int ZW  = gche_pkg::Z_W;
  localparam int HW  = gche_pkg::HEAD_W;
  localparam int PW  = gche_pkg::POS_W;
  localparam int DW  = gche_pkg::DIV_W;
  localparam int GW  = gche_pkg::DIGIT_W;
  localparam int SW  = gche_pkg::STEP_W;
  localparam int TW  = gche_pkg::TAB_W;
  localparam int RW  = ZW + 1 - gche_pkg::ANG_SH;
  localparam logic [HW:0] HALF    = (HW+1)'(1) << (HW - 1);
  localparam logic [HW:0] QUARTER = (HW+1)'(1) << (HW - 2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic                  valid_r, west_r, neg_r;
  logic signed [CW-1:0]  x_r, y_r;
  logic signed [ZW-1:0]  z_r;
  logic [DW-1:0]         num_e_r, num_n_r, quo_e_r, quo_n_r;
  logic [1:0]            rem_e_r, rem_n_r;
  logic [HW-1:0]         last_raw_r;
  logic                  res_valid_r, res_valid_nxt;
  gche_pkg::gche_result_t res_r;

  logic                  cordic_on, div_on, load, finish, res_free;
  logic signed [CW-1:0]  xs, ys;
  logic [ZW-1:0]         angle_step;
  logic [GW+1:0]         dig_e, dig_n;
  logic [ZW-1:0]         zc;
  logic [ZW:0]           zsum;
  logic [RW-1:0]         zr;
  logic [HW:0]           mag0, mag, nmag;
  logic [HW-1:0]         raw;
  logic [HW:0]           diff, ndiff, adiff;
  logic                  held;

  assign res_free  = !res_valid_r || res_pop;
  assign load      = (state_r == ST_IDLE) && !q_stat.empty;
  assign finish    = (state_r == ST_DONE) && res_free;
  assign q_pop     = load;
  assign cordic_on = (state_r == ST_RUN) && (int'(step_r) < gche_pkg::CORDIC_STEPS);
  assign div_on    = (state_r == ST_RUN) && (int'(step_r) < gche_pkg::DIV_DIGITS);

  // controller
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = job.valid ? ST_RUN : ST_DONE;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (step_r == SW'(gche_pkg::NSTEP - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      ST_DONE: begin
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath: one vectoring rotation per step, and one quotient digit per step for the first DIV_DIGITS steps
  assign xs         = x_r >>> step_r;
  assign ys         = y_r >>> step_r;
  assign angle_step = gche_pkg::atan_at(TW'(step_r));
  assign dig_e      = gche_pkg::div3_digit(rem_e_r, num_e_r[DW-1 -: GW]);
  assign dig_n      = gche_pkg::div3_digit(rem_n_r, num_n_r[DW-1 -: GW]);

  always_ff @(posedge clk) begin
    if (load) begin
      valid_r <= job.valid;
      west_r  <= job.west;
      neg_r   <= job.neg;
      x_r     <= {3'b000, job.ax, {gche_pkg::FRAC_SH{1'b0}}};
      y_r     <= {3'b000, job.ay, {gche_pkg::FRAC_SH{1'b0}}};
      z_r     <= '0;
      num_e_r <= DW'(job.sum_e);
      num_n_r <= DW'(job.sum_n);
      quo_e_r <= '0;
      quo_n_r <= '0;
      rem_e_r <= '0;
      rem_n_r <= '0;
    end else begin
      if (cordic_on) begin
        if (!y_r[CW-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + $signed(angle_step);
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - $signed(angle_step);
        end
      end
      if (div_on) begin
        num_e_r <= num_e_r << GW;
        num_n_r <= num_n_r << GW;
        quo_e_r <= {quo_e_r[DW-GW-1:0], dig_e[GW+1:2]};
        quo_n_r <= {quo_n_r[DW-GW-1:0], dig_n[GW+1:2]};
        rem_e_r <= dig_e[1:0];
        rem_n_r <= dig_n[1:0];
      end
    end
  end

  // final angle, sign and jump limit
  always_comb begin
    zc    = z_r[ZW-1] ? '0 : z_r;
    zsum  = {1'b0, zc} + ((ZW+1)'(1) << (gche_pkg::ANG_SH - 1));
    zr    = zsum[ZW:gche_pkg::ANG_SH];
    mag0  = ((HW+1)'(zr) > QUARTER) ? QUARTER : (HW+1)'(zr);
    mag   = west_r ? (HALF - mag0) : mag0;
    nmag  = (HW+1)'(-mag);
    if (neg_r) begin
      raw = nmag[HW-1:0];
    end else if (mag >= HALF) begin
      raw = {1'b0, {(HW-1){1'b1}}};
    end else begin
      raw = mag[HW-1:0];
    end
    diff  = {raw[HW-1], raw} - {last_raw_r[HW-1], last_raw_r};
    ndiff = (HW+1)'(-diff);
    adiff = diff[HW] ? ndiff : diff;
    held  = adiff > (HW+1)'(jump_limit);
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (valid_r) begin
        res_r.heading_valid  <= 1'b1;
        res_r.heading        <= held ? last_raw_r : raw;
        res_r.held_previous  <= held;
        res_r.centroid_east  <= quo_e_r[PW-1:0];
        res_r.centroid_north <= quo_n_r[PW-1:0];
      end else begin
        res_r <= '0;
      end
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (finish) begin
      res_valid_nxt = 1'b1;
    end else if (res_pop) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      last_raw_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      res_valid_r <= res_valid_nxt;
      if (finish && valid_r) begin
        last_raw_r <= raw;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // a job is only taken from the queue while the engine is idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE) && !q_stat.empty)
    else $error("job popped while engine busy");

  // a held heading is always a valid heading
  a_held_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.held_previous |-> res_r.heading_valid)
    else $error("held flag on invalid result");

  // an invalid result carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.heading_valid |->
      (res_r.heading == '0) && (res_r.centroid_east == '0) &&
      (res_r.centroid_north == '0))
    else $error("invalid result with nonzero fields");

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> !res_valid_r || res_pop)
    else $error("result register overwritten");

  // the reference heading only moves when a valid result is produced
  a_last_raw: assert property (@(posedge clk) disable iff (!rst_n)
    !(finish && valid_r) |=> $stable(last_raw_r))
    else $error("last raw heading changed without a valid result");

endmodule

`default_nettype wire

// ===== rtl/core/gps_course_heading_estimator_top.sv =====
// ----------------------------------------------------------------------------
// gps_course_heading_estimator_top: course heading from position fixes
// Use: push planar fixes (easting, northing in mm) into the in_ queue;
// pop one result per fix from the out_ queue. A result holds a validity
// flag, a signed binary-angle heading from east (32768 = pi), a flag set
// when the jump limit held the previous heading, and the rounded centroid
// of the three newest fixes. Until ten fixes are in, or when the span is
// zero or due east, the result is all zero.
// cfg_ channel: one write-only register, the jump limit (reset 3641, about
// 20 degrees); write it only while no fix is in flight.
// Flow: an accepted fix is queued, then the engine loads it, runs 16 vectoring
// steps and a finishing step; a fix with no heading skips the vectoring steps.
// The iterative angle engine (one rotation per cycle) works on one fix at a
// time and takes the next from the queue only once it has finished the last.
// Reset clears the window count, queue, engine state and result valid flag.
// When the receiver stalls, the result waits in its register, the engine
// holds its finished job and in_full rises once both queue slots are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_course_heading_estimator_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // fix input queue
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [gche_pkg::POS_W-1:0]   in_pos_east,
  input  wire logic [gche_pkg::POS_W-1:0]   in_pos_north,
  // result output queue
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic                              out_heading_valid,
  output logic [gche_pkg::HEAD_W-1:0]       out_heading,
  output logic                              out_held_previous,
  output logic [gche_pkg::POS_W-1:0]        out_centroid_east,
  output logic [gche_pkg::POS_W-1:0]        out_centroid_north,
  // jump limit register write
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [gche_pkg::LIMIT_W-1:0] cfg_jump_limit
);

  // jump limit register, always writable
  logic [gche_pkg::LIMIT_W-1:0] jump_limit_r, jump_limit_nxt;

  // front to queue
  logic                   fq_push;
  gche_pkg::gche_job_t    fq_job;
  // queue to back
  gche_pkg::gche_job_t    qb_job;
  gche_pkg::gche_qstat_t  q_stat;
  logic                   qb_pop;
  // back to output
  logic                   res_valid;
  gche_pkg::gche_result_t res;
  logic                   res_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    jump_limit_nxt = jump_limit_r;
    if (cfg_valid && cfg_ready) begin
      jump_limit_nxt = cfg_jump_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_limit_r <= gche_pkg::LIMIT_RESET;
    end else begin
      jump_limit_r <= jump_limit_nxt;
    end
  end

  // front: window shift and job classification per transfer
  gche_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_pos_east  (in_pos_east),
    .in_pos_north (in_pos_north),
    .q_stat       (q_stat),
    .q_push       (fq_push),
    .q_job        (fq_job)
  );

  // decoupling queue so the front keeps taking fixes while the engine works
  gche_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fq_push),
    .wr_job (fq_job),
    .pop    (qb_pop),
    .rd_job (qb_job),
    .stat   (q_stat)
  );

  // back: angle engine, jump limit, centroid and result register
  gche_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (qb_job),
    .q_stat     (q_stat),
    .q_pop      (qb_pop),
    .jump_limit (jump_limit_r),
    .res_pop    (res_pop),
    .res_valid  (res_valid),
    .res        (res)
  );

  // input side stalls only when the job queue is full
  assign in_full = q_stat.full;

  // result transfer
  assign out_empty          = !res_valid;
  assign res_pop            = out_pop && res_valid;
  assign out_heading_valid  = res.heading_valid;
  assign out_heading        = res.heading;
  assign out_held_previous  = res.held_previous;
  assign out_centroid_east  = res.centroid_east;
  assign out_centroid_north = res.centroid_north;

endmodule

`default_nettype wire
